// ===== rtl/monotonic_uuidv7_generator_top_macros.svh =====
// assertion macros for the monotonic uuidv7 generator checker
// expects clk_i and rst_ni in the scope where the macros are used
`ifndef MONOTONIC_UUIDV7_GENERATOR_TOP_MACROS_SVH
`define MONOTONIC_UUIDV7_GENERATOR_TOP_MACROS_SVH

// same-cycle implication
`define MUVG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("muvg assertion failed");

// next-cycle implication
`define MUVG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("muvg assertion failed");

`endif

// ===== rtl/muvg_pkg.sv =====
// shared types and constants for the monotonic uuidv7 generator
// no dependencies
package muvg_pkg;

  localparam int unsigned SeqW   = 12;
  localparam int unsigned MsW    = 48;
  localparam int unsigned WordW  = 64;
  localparam int unsigned FloorW = 60;
  localparam int unsigned TailW  = 62;

  localparam logic CMD_GENERATE = 1'b0;
  localparam logic CMD_RAISE    = 1'b1;

  localparam logic [3:0] VERSION_NIBBLE = 4'h7;
  localparam logic [1:0] VARIANT_BITS   = 2'b10;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_RNG_FAIL    = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_BAD_VARIANT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_GEN    = 2'd0,
    KIND_RAISE  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    status_e            status;
    logic [FloorW-1:0]  operand;
    logic [TailW-1:0]   tail;
  } entry_t;

endpackage

// ===== rtl/muvg_front.sv =====
// front end: accepts input transactions and classifies them into queue entries
// depends on muvg_pkg
module muvg_front import muvg_pkg::*; (
  input  logic                command_i,
  input  logic [MsW-1:0]      now_ms_i,
  input  logic [WordW-1:0]    random_tail_i,
  input  logic                rng_ok_i,
  input  logic [WordW-1:0]    import_high_i,
  input  logic [WordW-1:0]    import_low_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                queue_full_i,
  output logic                push_o,
  output entry_t              entry_o
);

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    entry_o.kind    = KIND_REJECT;
    entry_o.status  = ST_OK;
    entry_o.operand = '0;
    entry_o.tail    = random_tail_i[TailW-1:0];
    if (command_i == CMD_GENERATE) begin
      entry_o.operand = {{(FloorW-MsW){1'b0}}, now_ms_i};
      if (rng_ok_i) begin
        entry_o.kind = KIND_GEN;
      end else begin
        entry_o.status = ST_RNG_FAIL;
      end
    end else if (import_high_i[15:12] != VERSION_NIBBLE) begin
      entry_o.status = ST_BAD_VERSION;
    end else if (import_low_i[63:62] != VARIANT_BITS) begin
      entry_o.status = ST_BAD_VARIANT;
    end else begin
      entry_o.kind    = KIND_RAISE;
      // floor word: ms above the version nibble, sequence below it
      entry_o.operand = {import_high_i[63:16], import_high_i[SeqW-1:0]};
    end
  end

endmodule

// ===== rtl/muvg_queue.sv =====
// short queue between the front end and the back end
// depends on muvg_pkg
module muvg_queue import muvg_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/muvg_back.sv =====
// back end: reservation word update and registered identifier output
// depends on muvg_pkg
module muvg_back import muvg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              entry_valid_i,
  input  entry_t            entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WordW-1:0]  uuid_high_o,
  output logic [WordW-1:0]  uuid_low_o,
  output logic [1:0]        status_o
);

  logic [WordW-1:0] last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] uuid_high_q, uuid_high_d;
  logic [WordW-1:0] uuid_low_q, uuid_low_d;
  status_e          status_q;
  logic [WordW-1:0] next_word;
  logic [WordW-1:0] floor_word;
  logic             clock_ahead;

  assign pop_o = entry_valid_i && (!out_valid_q || out_ready_i);

  // wall clock ahead of logical ms restarts the sequence; otherwise the word counts up
  assign clock_ahead = {{(WordW-SeqW-MsW){1'b0}}, entry_i.operand[MsW-1:0]}
                       > last_q[WordW-1:SeqW];
  assign next_word   = clock_ahead
                       ? {{(WordW-SeqW-MsW){1'b0}}, entry_i.operand[MsW-1:0], {SeqW{1'b0}}}
                       : last_q + WordW'(1);
  assign floor_word  = {{(WordW-FloorW){1'b0}}, entry_i.operand};

  always_comb begin
    last_d      = last_q;
    uuid_high_d = '0;
    uuid_low_d  = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      out_valid_d = 1'b1;
      unique case (entry_i.kind)
        KIND_GEN: begin
          last_d      = next_word;
          uuid_high_d = {next_word[SeqW+MsW-1:SeqW], VERSION_NIBBLE, next_word[SeqW-1:0]};
          uuid_low_d  = {VARIANT_BITS, entry_i.tail};
        end
        KIND_RAISE: begin
          if (floor_word > last_q) begin
            last_d = floor_word;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      uuid_high_q <= uuid_high_d;
      uuid_low_q  <= uuid_low_d;
      status_q    <= entry_i.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign uuid_high_o = uuid_high_q;
  assign uuid_low_o  = uuid_low_q;
  assign status_o    = status_q;

endmodule

// ===== rtl/monotonic_uuidv7_generator_top.sv =====
// an accepted transaction is written into the queue, then its result is registered in the back end output stage
// throughput: one transaction per cycle while the output is not stalled, set by the reservation word update
// the queue between front and back ends absorbs output stalls for QueueDepth entries
// reset: reservation word cleared to zero, queue and output register empty
// depends on muvg_pkg, muvg_front, muvg_queue, muvg_back
module monotonic_uuidv7_generator_top import muvg_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [MsW-1:0]    now_ms_i,
  input  logic [WordW-1:0]  random_tail_i,
  input  logic              rng_ok_i,
  input  logic [WordW-1:0]  import_high_i,
  input  logic [WordW-1:0]  import_low_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WordW-1:0]  uuid_high_o,
  output logic [WordW-1:0]  uuid_low_o,
  output logic [1:0]        status_o
);

  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_valid;
  entry_t push_entry;
  entry_t head_entry;

  muvg_front u_front (
    .command_i     (command_i),
    .now_ms_i      (now_ms_i),
    .random_tail_i (random_tail_i),
    .rng_ok_i      (rng_ok_i),
    .import_high_i (import_high_i),
    .import_low_i  (import_low_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  muvg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .entry_o (head_entry)
  );

  muvg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (queue_valid),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .uuid_high_o   (uuid_high_o),
    .uuid_low_o    (uuid_low_o),
    .status_o      (status_o)
  );

endmodule

// ===== rtl/muvg_checker.sv =====
// port-level checks for the monotonic uuidv7 generator, bound to the top level
// depends on muvg_pkg and monotonic_uuidv7_generator_top_macros.svh
`include "monotonic_uuidv7_generator_top_macros.svh"

module muvg_checker import muvg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              command_i,
  input logic [MsW-1:0]    now_ms_i,
  input logic [WordW-1:0]  random_tail_i,
  input logic              rng_ok_i,
  input logic [WordW-1:0]  import_high_i,
  input logic [WordW-1:0]  import_low_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [WordW-1:0]  uuid_high_o,
  input logic [WordW-1:0]  uuid_low_o,
  input logic [1:0]        status_o
);

  // stalled result holds
  `MUVG_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(uuid_high_o) && $stable(uuid_low_o) && $stable(status_o))

  // failed transactions carry no identifier
  `MUVG_ASSERT_NOW(a_fail_zero, out_valid_o && (status_o != ST_OK), (uuid_high_o == '0) && (uuid_low_o == '0))

  // issued identifiers carry version and variant
  `MUVG_ASSERT_NOW(a_ver_var, out_valid_o && (status_o == ST_OK) && (uuid_high_o != '0), (uuid_high_o[15:12] == VERSION_NIBBLE) && (uuid_low_o[63:62] == VARIANT_BITS))

endmodule

bind monotonic_uuidv7_generator_top muvg_checker u_muvg_checker (.*);

// ===== test/tb.sv =====
// testbench for monotonic_uuidv7_generator_top: directed and random transactions,
// results checked against an internal model of the reservation word
// depends on muvg_pkg and the generator rtl
module tb import muvg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WordW-1:0] hi;
    logic [WordW-1:0] lo;
    status_e          status;
  } uuid_result_t;

  class uuid_tracker;
    logic [WordW-1:0] reservation;
    uuid_result_t     awaited_ids[$];
    int               errors;

    function new();
      reservation = '0;
      errors      = 0;
    endfunction

    function void predict_issue(logic cmd, logic [MsW-1:0] now, logic [WordW-1:0] tail,
                                logic ok, logic [WordW-1:0] ih, logic [WordW-1:0] il);
      uuid_result_t           r;
      logic [WordW-SeqW-1:0]  prev_ms;
      logic [WordW-SeqW-1:0]  next_ms;
      logic [SeqW-1:0]        held_seq;
      logic [SeqW-1:0]        next_seq;
      logic [WordW-1:0]       floor_word;
      r = '0;
      r.status = ST_OK;
      if (cmd == CMD_GENERATE) begin
        if (!ok) begin
          r.status = ST_RNG_FAIL;
        end else begin
          prev_ms  = reservation[WordW-1:SeqW];
          held_seq = reservation[SeqW-1:0];
          if ({4'b0, now} > prev_ms) begin
            next_ms  = {4'b0, now};
            next_seq = '0;
          end else if (held_seq != '1) begin
            next_ms  = prev_ms;
            next_seq = held_seq + SeqW'(1);
          end else begin
            // sequence exhausted, borrow the next millisecond (wraps at 52 bits)
            next_ms  = prev_ms + (WordW-SeqW)'(1);
            next_seq = '0;
          end
          reservation = {next_ms, next_seq};
          r.hi = {next_ms[MsW-1:0], VERSION_NIBBLE, next_seq};
          r.lo = {VARIANT_BITS, tail[TailW-1:0]};
        end
      end else if (ih[15:12] != VERSION_NIBBLE) begin
        r.status = ST_BAD_VERSION;
      end else if (il[63:62] != VARIANT_BITS) begin
        r.status = ST_BAD_VARIANT;
      end else begin
        floor_word = {4'b0, ih[63:16], ih[SeqW-1:0]};
        if (floor_word > reservation) reservation = floor_word;
      end
      awaited_ids.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_issue(logic [WordW-1:0] hi, logic [WordW-1:0] lo, logic [1:0] st);
      uuid_result_t exp_id;
      if (awaited_ids.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h_%h status %0d", hi, lo, st));
      end else begin
        exp_id = awaited_ids.pop_front();
        if (hi !== exp_id.hi)
          report_mismatch($sformatf("uuid_high %h, wanted %h", hi, exp_id.hi));
        if (lo !== exp_id.lo)
          report_mismatch($sformatf("uuid_low %h, wanted %h", lo, exp_id.lo));
        if (st !== exp_id.status)
          report_mismatch($sformatf("status %0d, wanted %0d", st, exp_id.status));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             command_i;
  logic [MsW-1:0]   now_ms_i;
  logic [WordW-1:0] random_tail_i;
  logic             rng_ok_i;
  logic [WordW-1:0] import_high_i;
  logic [WordW-1:0] import_low_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [WordW-1:0] uuid_high_o;
  logic [WordW-1:0] uuid_low_o;
  logic [1:0]       status_o;

  uuid_tracker sb = new();
  bit          quiet = 1'b0;

  monotonic_uuidv7_generator_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .now_ms_i      (now_ms_i),
    .random_tail_i (random_tail_i),
    .rng_ok_i      (rng_ok_i),
    .import_high_i (import_high_i),
    .import_low_i  (import_low_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .uuid_high_o   (uuid_high_o),
    .uuid_low_o    (uuid_low_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    command_i     = CMD_GENERATE;
    now_ms_i      = '0;
    random_tail_i = '0;
    rng_ok_i      = 1'b0;
    import_high_i = '0;
    import_low_i  = '0;
    out_ready_i   = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  function automatic logic [WordW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(logic cmd, logic [MsW-1:0] now, logic [WordW-1:0] tail,
                              logic ok, logic [WordW-1:0] ih, logic [WordW-1:0] il);
    if (!quiet) begin
      while ($urandom_range(99) < 9) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    now_ms_i      <= now;
    random_tail_i <= tail;
    rng_ok_i      <= ok;
    import_high_i <= ih;
    import_low_i  <= il;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.predict_issue(cmd, now, tail, ok, ih, il);
  endtask

  task automatic generate_id(logic [MsW-1:0] now, logic [WordW-1:0] tail, logic ok);
    send_request(CMD_GENERATE, now, tail, ok, rand64(), rand64());
  endtask

  task automatic raise_floor(logic [WordW-1:0] ih, logic [WordW-1:0] il);
    logic [WordW-1:0] noise;
    noise = rand64();
    send_request(CMD_RAISE, noise[MsW-1:0], rand64(), noise[63], ih, il);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.awaited_ids.size() != 0) @(posedge clk_i);
  endtask

  // result side: random back-pressure and checking
  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= 9);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_issue(uuid_high_o, uuid_low_o, status_o);
  end

  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [MsW-1:0]   wall_ms;
    logic [MsW-1:0]   now;
    logic [MsW-1:0]   floor_ms;
    logic [SeqW-1:0]  floor_seq;
    logic [WordW-1:0] ih;
    logic [WordW-1:0] il;
    int               pick;
    int               step;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: first ids, rng failure, clock behind, tail extremes
    generate_id('0, '0, 1'b1);
    generate_id('0, '1, 1'b1);
    generate_id(48'd5, rand64(), 1'b0);
    generate_id(48'd5, rand64(), 1'b1);
    generate_id(48'd3, rand64(), 1'b1);
    // imports with bad version, each bad variant, then a floor below the word
    raise_floor({48'd100, 4'h0, 12'd0}, {VARIANT_BITS, 62'd0});
    raise_floor({48'd100, 4'hf, 12'd0}, {VARIANT_BITS, 62'd0});
    raise_floor({48'd100, VERSION_NIBBLE, 12'd0}, {2'b00, 62'h3fff_ffff_ffff_ffff});
    raise_floor({48'd100, VERSION_NIBBLE, 12'd0}, {2'b01, 62'd0});
    raise_floor({48'd100, VERSION_NIBBLE, 12'd0}, {2'b11, 62'd0});
    raise_floor({48'd1, VERSION_NIBBLE, 12'd7}, {VARIANT_BITS, 62'd0});
    // floor just under sequence exhaustion, then carry into the next ms
    raise_floor({48'd9, VERSION_NIBBLE, 12'hffe}, {VARIANT_BITS, 62'h1234_5678_9abc_def0});
    generate_id(48'd9, rand64(), 1'b1);
    generate_id(48'd2, rand64(), 1'b1);
    raise_floor({48'd20, VERSION_NIBBLE, 12'hfff}, rand64() | {VARIANT_BITS, 62'd0}
                & {2'b10, 62'h3fff_ffff_ffff_ffff});
    generate_id('0, rand64(), 1'b1);
    generate_id(48'd22, rand64(), 1'b1);
    generate_id(48'd22, rand64(), 1'b0);
    generate_id(48'd23, rand64(), 1'b1);
    drain_results();

    wall_ms = 48'd30;
    for (int i = 0; i < 1100; i++) begin
      quiet = (i >= 300 && i < 550);
      if (i == 700) drain_results();
      pick = $urandom_range(99);
      if (pick < 8) begin
        // good import close to the current word, often near exhaustion
        floor_ms = sb.reservation[MsW+SeqW-1:SeqW];
        step = $urandom_range(0, 3);
        if ($urandom_range(1)) floor_ms = floor_ms + MsW'(step);
        else if (floor_ms > 3) floor_ms = floor_ms - MsW'(step);
        floor_seq = SeqW'($urandom_range(1) ? $urandom_range(4088, 4095)
                                            : $urandom_range(0, 4095));
        il = rand64();
        il[63:62] = VARIANT_BITS;
        raise_floor({floor_ms, VERSION_NIBBLE, floor_seq}, il);
      end else if (pick < 14) begin
        // malformed import
        ih = rand64();
        il = rand64();
        if ($urandom_range(1)) begin
          while (ih[15:12] == VERSION_NIBBLE) ih[15:12] = 4'($urandom_range(0, 15));
        end else begin
          ih[15:12] = VERSION_NIBBLE;
          while (il[63:62] == VARIANT_BITS) il[63:62] = 2'($urandom_range(0, 3));
        end
        raise_floor(ih, il);
      end else if (pick < 20) begin
        now = MsW'(rand64());
        generate_id(now, rand64(), 1'b0);
      end else begin
        step = $urandom_range(99);
        now  = wall_ms;
        if (step < 45) begin
          now = wall_ms;
        end else if (step < 75) begin
          wall_ms = wall_ms + MsW'($urandom_range(1, 3));
          now = wall_ms;
        end else if (step < 87) begin
          now = (wall_ms > 5) ? wall_ms - MsW'($urandom_range(0, 5)) : '0;
        end else begin
          wall_ms = wall_ms + MsW'($urandom_range(0, 1 << $urandom_range(0, 30)));
          now = wall_ms;
        end
        generate_id(now, rand64(), 1'b1);
      end
    end

    // closing: word pushed past 48 bits of ms, clock can never catch up again
    raise_floor({48'hffff_ffff_ffff, VERSION_NIBBLE, 12'hfff}, {VARIANT_BITS, 62'd0});
    generate_id('1, rand64(), 1'b1);
    generate_id('1, rand64(), 1'b1);
    generate_id('0, rand64(), 1'b1);
    raise_floor({48'hffff_ffff_ffff, VERSION_NIBBLE, 12'h000}, {VARIANT_BITS, 62'd0});
    generate_id('1, '1, 1'b1);
    generate_id('1, rand64(), 1'b0);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
